@@ hw/rtl/pfir_pkg.sv @@
// ----------------------------------------------------------------------------
// pfir_pkg: shared types and constants of the frame index ring
// Request codes, the stored entry layout and the compare unit result.
// ----------------------------------------------------------------------------
`default_nettype none

package pfir_pkg;

    // Request codes carried on the input tuser field.
    localparam logic [2:0] REQ_PUT     = 3'd0;
    localparam logic [2:0] REQ_NEAREST = 3'd1;
    localparam logic [2:0] REQ_FRAME   = 3'd2;
    localparam logic [2:0] REQ_CLEAR   = 3'd3;
    localparam logic [2:0] REQ_QEMPTY  = 3'd4;

    // Distance constants for the wrap folding.
    localparam logic [31:0] DIST_MAX  = 32'hFFFF_FFFF;
    localparam logic [31:0] DIST_HALF = 32'h7FFF_FFFF;

    // Number of unplayed intra entries that end a frame-number scan.
    localparam logic [1:0] UNPLAYED_LIMIT = 2'd2;

    // One ring entry as held in the memory.
    typedef struct packed {
        logic        intra;
        logic [30:0] index;
        logic [31:0] stamp;
    } pfir_entry_t;

    // Result of comparing a target stamp against one entry.
    typedef struct packed {
        logic        played;
        logic [31:0] span;
    } pfir_cmp_t;

endpackage

`default_nettype wire

@@ hw/rtl/pts_frame_index_ring.sv @@
// ----------------------------------------------------------------------------
// pts_frame_index_ring: ring of presentation stamps with frame indexes
// Stores stamp entries and answers nearest-index, frame-number and query-empty requests.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the s_axis channel, request code in tuser. A put
// or clear word gives no result. A query word (nearest, frame number, query
// empty) gives one result word on m_axis.
// Timing: the block scans the ring through a single memory read port, one
// entry per cycle, with one compare unit. A nearest query scans every held
// entry; a frame-number query scans up to all of them, then runs the nearest
// search when it finds no played intra entry. A query on an empty ring and a
// query-empty request skip the scan. While a query is scanned s_axis_tready
// is low; puts and clears are taken back to back.
// Stall: the result sits in an output register; further puts and clears
// are accepted while it waits, and a finished query waits for the slot.
// Reset: aresetn (synchronous, active low) empties the ring and clears the
// remembered index; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_frame_index_ring
    import pfir_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // stamp[31:0], frame_index[62:32], is_intra[63]
    input  wire logic [2:0]  s_axis_tuser,  // req_type[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // result_index[30:0], table_empty[31]
);

    localparam int PW = $clog2(ENTRIES);
    localparam logic [PW-1:0] LAST_PTR = PW'(ENTRIES - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_NEAR  = 2'd1;
    localparam logic [1:0] ST_FRAME = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [30:0]   last_found_reg, last_found_next;
    logic [31:0]   target_reg, target_next;
    logic [PW-1:0] addr_reg, addr_next;
    logic [PW-1:0] left_reg, left_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [31:0]   best_reg, best_next;
    logic [30:0]   found_reg, found_next;
    logic [30:0]   count_reg, count_next;
    logic          fvalid_reg, fvalid_next;
    logic [1:0]    unplayed_reg, unplayed_next;
    logic [30:0]   res_reg, res_next;
    logic          empty_reg, empty_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_tdata_reg, m_tdata_next;

    logic          accept;
    logic          ring_empty;
    logic [PW:0]   fill_wide;
    logic [PW-1:0] fill;
    logic [PW-1:0] wp_inc;
    logic [PW-1:0] rp_inc;
    logic [PW-1:0] addr_inc;
    logic [PW-1:0] addr_dec;
    logic [PW-1:0] rd_addr;
    logic          wr_en;
    pfir_entry_t   wr_data;
    pfir_entry_t   rd_data;
    pfir_cmp_t     cmp;
    logic          frame_done;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // Ring occupancy and pointer steps.
    always_comb begin
        ring_empty = (wp_reg == rp_reg);
        fill_wide  = (wp_reg >= rp_reg) ? ({1'b0, wp_reg} - {1'b0, rp_reg})
                   : ({1'b0, wp_reg} + (PW+1)'(ENTRIES) - {1'b0, rp_reg});
        fill       = fill_wide[PW-1:0];
        wp_inc     = (wp_reg == LAST_PTR) ? '0 : wp_reg + PW'(1);
        rp_inc     = (rp_reg == LAST_PTR) ? '0 : rp_reg + PW'(1);
        addr_inc   = (addr_reg == LAST_PTR) ? '0 : addr_reg + PW'(1);
        addr_dec   = (addr_reg == '0) ? LAST_PTR : addr_reg - PW'(1);
    end

    // Entry memory and the shared compare unit.
    assign wr_en         = accept && (s_axis_tuser == REQ_PUT);
    assign wr_data.stamp = s_axis_tdata[31:0];
    assign wr_data.index = s_axis_tdata[62:32];
    assign wr_data.intra = s_axis_tdata[63];
    assign rd_addr       = (state_reg == ST_NEAR) ? addr_dec : addr_reg;

    pfir_ring_mem #(
        .DEPTH (ENTRIES),
        .AW    (PW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfir_dist_unit u_dist (
        .target      (target_reg),
        .entry_stamp (rd_data.stamp),
        .cmp         (cmp)
    );

    // The frame scan ends when all entries are seen or two unplayed intras passed.
    assign frame_done = ((left_reg == '0) && !cmp_valid_reg) || (unplayed_reg == '0);

    // Sequencer: request decode, the two scans and the result hand-off.
    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        last_found_next = last_found_reg;
        target_next     = target_reg;
        addr_next       = addr_reg;
        left_next       = left_reg;
        cmp_valid_next  = 1'b0;
        best_next       = best_reg;
        found_next      = found_reg;
        count_next      = count_reg;
        fvalid_next     = fvalid_reg;
        unplayed_next   = unplayed_reg;
        res_next        = res_reg;
        empty_next      = empty_reg;
        m_tvalid_next   = m_tvalid_reg && !m_axis_tready;
        m_tdata_next    = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    target_next = s_axis_tdata[31:0];
                    empty_next  = ring_empty;
                    case (s_axis_tuser)
                        REQ_PUT: begin
                            wp_next = wp_inc;
                            if (wp_inc == rp_reg) begin
                                rp_next = rp_inc;
                            end
                        end
                        REQ_NEAREST: begin
                            if (ring_empty) begin
                                res_next   = last_found_reg;
                                state_next = ST_OUT;
                            end else begin
                                addr_next  = wp_reg;
                                left_next  = fill;
                                best_next  = DIST_MAX;
                                found_next = '0;
                                state_next = ST_NEAR;
                            end
                        end
                        REQ_FRAME: begin
                            if (ring_empty) begin
                                res_next   = last_found_reg;
                                state_next = ST_OUT;
                            end else begin
                                addr_next     = rp_reg;
                                left_next     = fill;
                                count_next    = '0;
                                fvalid_next   = 1'b0;
                                unplayed_next = UNPLAYED_LIMIT;
                                state_next    = ST_FRAME;
                            end
                        end
                        REQ_CLEAR: begin
                            wp_next = '0;
                            rp_next = '0;
                        end
                        REQ_QEMPTY: begin
                            res_next   = '0;
                            state_next = ST_OUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_NEAR: begin
                // Issue the next older entry while the previous one is compared.
                if (left_reg != '0) begin
                    addr_next      = addr_dec;
                    left_next      = left_reg - PW'(1);
                    cmp_valid_next = 1'b1;
                end
                if (cmp_valid_reg && (cmp.span < best_reg)) begin
                    best_next  = cmp.span;
                    found_next = rd_data.index;
                end
                if ((left_reg == '0) && !cmp_valid_reg) begin
                    last_found_next = found_reg;
                    res_next        = found_reg;
                    state_next      = ST_OUT;
                end
            end

            ST_FRAME: begin
                if (frame_done) begin
                    if (fvalid_reg) begin
                        res_next   = count_reg;
                        state_next = ST_OUT;
                    end else begin
                        // No played intra entry: fall back to the nearest search.
                        addr_next  = wp_reg;
                        left_next  = fill;
                        best_next  = DIST_MAX;
                        found_next = '0;
                        state_next = ST_NEAR;
                    end
                end else begin
                    if (left_reg != '0) begin
                        addr_next      = addr_inc;
                        left_next      = left_reg - PW'(1);
                        cmp_valid_next = 1'b1;
                    end
                    if (cmp_valid_reg) begin
                        if (cmp.played) begin
                            if (rd_data.intra) begin
                                count_next  = rd_data.index;
                                fvalid_next = 1'b1;
                            end else begin
                                count_next = count_reg + 31'd1;
                            end
                        end else if (rd_data.intra) begin
                            unplayed_next = unplayed_reg - 2'd1;
                        end
                    end
                end
            end

            ST_OUT: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {empty_reg, res_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            last_found_reg <= '0;
            cmp_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            last_found_reg <= last_found_next;
            cmp_valid_reg  <= cmp_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Scan and result payload.
    always_ff @(posedge aclk) begin
        target_reg   <= target_next;
        addr_reg     <= addr_next;
        left_reg     <= left_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        count_reg    <= count_next;
        fvalid_reg   <= fvalid_next;
        unplayed_reg <= unplayed_next;
        res_reg      <= res_next;
        empty_reg    <= empty_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/pfir_ring_mem.sv @@
// ----------------------------------------------------------------------------
// pfir_ring_mem: entry storage of the frame index ring
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfir_ring_mem
    import pfir_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic        aclk,
    input  wire logic        wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire pfir_entry_t wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output pfir_entry_t      rd_data
);

    pfir_entry_t mem [DEPTH];

    // Write side: one entry per put request.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read side: the data is registered and appears in the cycle after the address.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/pfir_dist_unit.sv @@
// ----------------------------------------------------------------------------
// pfir_dist_unit: stamp compare unit shared by both scans
// Gives the wrap-folded distance and the played flag for one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pfir_dist_unit
    import pfir_pkg::*;
(
    input  wire logic [31:0] target,
    input  wire logic [31:0] entry_stamp,
    output pfir_cmp_t        cmp
);

    logic [31:0] diff;
    logic [31:0] abs_diff;

    // Signed difference decides played; the absolute one is folded at half range.
    always_comb begin
        diff       = target - entry_stamp;
        abs_diff   = (entry_stamp < target) ? diff : (entry_stamp - target);
        cmp.played = (diff != 32'd0) && !diff[31];
        cmp.span   = (abs_diff > DIST_HALF) ? (DIST_MAX - abs_diff) : abs_diff;
    end

endmodule

`default_nettype wire

@@ hw/rtl/pfir_checker.sv @@
// ----------------------------------------------------------------------------
// pfir_checker: port-level checks of the frame index ring
// Watches the stream ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module pfir_checker
    import pfir_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [2:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready
);

    logic s_word;

    assign s_word = s_axis_tvalid && s_axis_tready;

    // A result word that is not taken stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped before it was taken");

    // Reset leaves no result word pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // Puts and clears leave the sequencer idle, so the input side stays open.
    a_put_clear_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_word && (s_axis_tuser == REQ_PUT || s_axis_tuser == REQ_CLEAR)
        |=> s_axis_tready)
        else $error("input not ready after a put or clear");

    // A query occupies the sequencer, so the input side closes behind it.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_word && (s_axis_tuser == REQ_NEAREST || s_axis_tuser == REQ_FRAME ||
                   s_axis_tuser == REQ_QEMPTY)
        |=> !s_axis_tready)
        else $error("input still ready while a query is in work");

endmodule

bind pts_frame_index_ring pfir_checker u_pfir_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the presentation stamp frame index ring
// Drives request words on s_axis and predicts every result word in the bench
// itself. A short table of hand-picked words comes first, then a long run of
// frame-like put streams with nearest and frame-number queries, noise words,
// and one longer run whose stamps cross the 32-bit wrap. Both channels idle
// at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import pfir_pkg::*;

    localparam int RING_DEPTH = 1024;

    // Request codes that the block must ignore.
    localparam logic [2:0] REQ_UNUSED5 = 3'd5;
    localparam logic [2:0] REQ_UNUSED6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED7 = 3'd7;

    localparam int RANDOM_WORDS = 555;
    localparam int FILL_PUTS    = 48;
    localparam int REPORT_LIMIT = 10;

    // One request word, with an optional hand-typed result.
    typedef struct {
        logic [2:0]  req;
        logic [31:0] stamp;
        logic [30:0] fidx;
        logic        intra;
        bit          pinned;
        logic [30:0] pin_index;
        logic        pin_empty;
    } req_word_t;

    typedef struct {
        logic [30:0] index;
        logic        empty;
    } result_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;  // stamp[31:0], frame_index[62:32], is_intra[63]
    logic [2:0]  s_axis_tuser  = '0;  // req_type[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // result_index[30:0], table_empty[31]

    bit          idle_on = 1'b1;

    // Bench copy of the ring.
    logic [31:0] ring_stamp [RING_DEPTH];
    logic [30:0] ring_index [RING_DEPTH];
    logic        ring_intra [RING_DEPTH];
    int unsigned head_ptr = 0;
    int unsigned tail_ptr = 0;
    logic [30:0] remembered_index = '0;

    result_t     expected_results [$];
    req_word_t   directed_rows [25];

    int unsigned fault_count   = 0;
    int unsigned words_sent    = 0;
    int unsigned useful_words  = 0;
    int unsigned results_seen  = 0;
    int unsigned peak_entries  = 0;
    int unsigned wrap_drops    = 0;

    pts_frame_index_ring #(
        .ENTRIES(RING_DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Ring predictor
    // ------------------------------------------------------------------
    function automatic int unsigned ring_fwd(int unsigned p);
        return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int unsigned ring_back(int unsigned p);
        return (p == 0) ? RING_DEPTH - 1 : p - 1;
    endfunction

    function automatic int unsigned ring_fill();
        return (head_ptr + RING_DEPTH - tail_ptr) % RING_DEPTH;
    endfunction

    // Closest stamp under wrap folding, newest entry wins a tie.
    function automatic logic [30:0] closest_index(logic [31:0] target);
        logic [31:0] best;
        logic [31:0] span;
        logic [30:0] hit;
        int unsigned p;
        if (head_ptr == tail_ptr) return remembered_index;
        best = DIST_MAX;
        hit  = '0;
        p    = head_ptr;
        while (p != tail_ptr) begin
            p = ring_back(p);
            span = (ring_stamp[p] < target) ? target - ring_stamp[p]
                                            : ring_stamp[p] - target;
            if (span > DIST_HALF) span = DIST_MAX - span;
            if (span < best) begin
                best = span;
                hit  = ring_index[p];
            end
        end
        remembered_index = hit;
        return hit;
    endfunction

    // Frame count from the last played intra entry, oldest first. Two
    // unplayed intra entries end the scan; no played intra means a
    // fallback to the closest stamp.
    function automatic logic [30:0] frame_number_at(logic [31:0] target);
        logic [31:0] diff;
        logic [30:0] count;
        logic        seen_intra;
        logic [1:0]  unplayed_left;
        int unsigned p;
        if (head_ptr == tail_ptr) return remembered_index;
        count         = '0;
        seen_intra    = 1'b0;
        unplayed_left = UNPLAYED_LIMIT;
        p             = tail_ptr;
        while (p != head_ptr && unplayed_left != 0) begin
            diff = target - ring_stamp[p];
            if ($signed(diff) > 0) begin
                if (ring_intra[p]) begin
                    count      = ring_index[p];
                    seen_intra = 1'b1;
                end else begin
                    count = count + 31'd1;
                end
            end else if (ring_intra[p]) begin
                unplayed_left = unplayed_left - 2'd1;
            end
            p = ring_fwd(p);
        end
        return seen_intra ? count : closest_index(target);
    endfunction

    // Apply one accepted word to the bench ring and work out its result.
    task automatic apply_request(input req_word_t w, output bit has_result,
                                 output result_t res);
        bit was_empty;
        was_empty  = (head_ptr == tail_ptr);
        has_result = 1'b0;
        res.index  = '0;
        res.empty  = was_empty;
        case (w.req)
            REQ_PUT: begin
                ring_stamp[head_ptr] = w.stamp;
                ring_index[head_ptr] = w.fidx;
                ring_intra[head_ptr] = w.intra;
                head_ptr = ring_fwd(head_ptr);
                if (head_ptr == tail_ptr) begin
                    tail_ptr   = ring_fwd(tail_ptr);
                    wrap_drops = wrap_drops + 1;
                end
                if (ring_fill() > peak_entries) peak_entries = ring_fill();
            end
            REQ_NEAREST: begin
                res.index  = closest_index(w.stamp);
                has_result = 1'b1;
            end
            REQ_FRAME: begin
                res.index  = frame_number_at(w.stamp);
                has_result = 1'b1;
            end
            REQ_CLEAR: begin
                head_ptr = 0;
                tail_ptr = 0;
            end
            REQ_QEMPTY: begin
                has_result = 1'b1;
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic note_fault(input string msg);
        fault_count = fault_count + 1;
        if (fault_count <= REPORT_LIMIT) $display("tb: mismatch: %s", msg);
    endtask

    // Compare every result word with the oldest expectation.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen = results_seen + 1;
            if (expected_results.size() == 0) begin
                note_fault($sformatf("result word %0h with nothing expected",
                                     m_axis_tdata));
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[30:0] !== want.index)
                    note_fault($sformatf("result %0d result_index exp %0h got %0h",
                                         results_seen, want.index, m_axis_tdata[30:0]));
                if (m_axis_tdata[31] !== want.empty)
                    note_fault($sformatf("result %0d table_empty exp %0b got %0b",
                                         results_seen, want.empty, m_axis_tdata[31]));
            end
        end
    end

    // Result side: after each word taken, stall at random before taking the next.
    always @(posedge aclk) begin : result_stall
        int unsigned stall_left;
        int unsigned draw;
        if (m_axis_tvalid && m_axis_tready) begin
            draw = idle_on ? $urandom_range(0, 3) : 0;
            stall_left = draw;
            m_axis_tready <= (draw == 0);
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= (stall_left == 0);
        end else begin
            m_axis_tready <= aresetn;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic req_word_t word_of(logic [2:0] req, logic [31:0] stamp,
                                          logic [30:0] fidx, logic intra);
        req_word_t w;
        w.req       = req;
        w.stamp     = stamp;
        w.fidx      = fidx;
        w.intra     = intra;
        w.pinned    = 1'b0;
        w.pin_index = '0;
        w.pin_empty = 1'b0;
        return w;
    endfunction

    // Query target: anywhere, exactly on a stamp, or close to one.
    function automatic logic [31:0] pick_target(logic [31:0] anchor,
                                                int unsigned spread);
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return anchor;
            default: return anchor + $urandom_range(0, 2 * spread) - spread;
        endcase
    endfunction

    // Send one request word and record what it should produce.
    task automatic send_word(input req_word_t w);
        int unsigned gap;
        bit          has_result;
        result_t     res;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.intra, w.fidx, w.stamp};
        s_axis_tuser  <= w.req;
        do @(posedge aclk); while (!s_axis_tready);
        apply_request(w, has_result, res);
        if (has_result) begin
            if (w.pinned) begin
                res.index = w.pin_index;
                res.empty = w.pin_empty;
            end
            expected_results.push_back(res);
        end
        words_sent = words_sent + 1;
        if (w.req <= REQ_QEMPTY) useful_words = useful_words + 1;
    endtask

    // Hold the input quiet until every expected result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic send_query(input logic [31:0] target);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_word(word_of(REQ_NEAREST, target, 31'($urandom),
                                          1'($urandom)));
            9:          send_word(word_of(REQ_QEMPTY, target, 31'($urandom),
                                          1'($urandom)));
            default:    send_word(word_of(REQ_FRAME, target, 31'($urandom),
                                          1'($urandom)));
        endcase
    endtask

    // A run of puts shaped like a coded video stream, with queries mixed in.
    // Scrambled runs carry arbitrary stamps and intra flags.
    task automatic stream_episode();
        logic [31:0] anchor;
        logic [31:0] stamp;
        logic [30:0] fbase;
        int unsigned step;
        int unsigned gop;
        int unsigned n;
        bit          scrambled;
        anchor    = $urandom;
        step      = $urandom_range(1, 4000);
        gop       = $urandom_range(1, 10);
        n         = $urandom_range(1, 20);
        scrambled = ($urandom_range(0, 4) == 0);
        fbase     = ($urandom_range(0, 5) == 0)
                  ? 31'h7FFF_FFFF - 31'($urandom_range(0, 8))
                  : 31'($urandom);
        stamp     = anchor;
        if (ring_fill() > 40 || $urandom_range(0, 3) == 0)
            send_word(word_of(REQ_CLEAR, $urandom, 31'($urandom), 1'($urandom)));
        for (int unsigned k = 0; k < n; k++) begin
            if (scrambled) begin
                stamp = ($urandom_range(0, 1) == 0) ? $urandom
                                                    : anchor + $urandom_range(0, 20000);
                send_word(word_of(REQ_PUT, stamp, 31'($urandom), 1'($urandom)));
            end else begin
                // Occasional out-of-order stamp, as with reordered frames.
                stamp = anchor + k * step;
                if ($urandom_range(0, 5) == 0) stamp = stamp - step;
                send_word(word_of(REQ_PUT, stamp, fbase + 31'(k), (k % gop) == 0));
            end
            if ($urandom_range(0, 2) == 0) send_query(pick_target(stamp, step * gop));
        end
        repeat ($urandom_range(0, 2)) send_query(pick_target(anchor, step * n));
    endtask

    // Arbitrary words, unused request codes among them.
    task automatic noise_episode();
        repeat (8) begin
            send_word(word_of(3'($urandom_range(0, 7)), $urandom, 31'($urandom),
                              1'($urandom)));
        end
    endtask

    // A longer run of puts whose stamps cross the 32-bit wrap.
    task automatic fill_episode();
        logic [31:0] base;
        logic [31:0] stamp;
        base = 32'hFFFF_0000 + $urandom_range(0, 65535);
        wait_drained();
        send_word(word_of(REQ_CLEAR, 32'h0, 31'h0, 1'b0));
        for (int unsigned k = 0; k < FILL_PUTS; k++) begin
            stamp = base + k * 3600;
            send_word(word_of(REQ_PUT, stamp, 31'($urandom), (k % 12) == 0));
        end
        repeat (8) send_query(pick_target(base + $urandom_range(0, FILL_PUTS) * 3600, 8000));
        send_word(word_of(REQ_QEMPTY, 32'h0, 31'h0, 1'b0));
        wait_drained();
        send_word(word_of(REQ_CLEAR, 32'h0, 31'h0, 1'b0));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        bit fill_done;
        int unsigned random_start;
        fill_done = 1'b0;

        // Hand-picked words: empty ring, stamp and index extremes, wrap
        // folding with a tie, clear keeping the remembered index, frame
        // count wrap, the two-unplayed-intra stop, the fallback to the
        // closest stamp, unused codes, and a played entry across the wrap.
        directed_rows = '{
            '{REQ_QEMPTY,  32'h0000_0000, 31'h0,         1'b0, 1'b1, 31'h0,         1'b1},
            '{REQ_NEAREST, 32'h1234_5678, 31'h0,         1'b0, 1'b1, 31'h0,         1'b1},
            '{REQ_FRAME,   32'hFFFF_FFFF, 31'h0,         1'b0, 1'b1, 31'h0,         1'b1},
            '{REQ_PUT,     32'h0000_0000, 31'h0,         1'b1, 1'b0, 31'h0,         1'b0},
            '{REQ_PUT,     32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0, 1'b0, 31'h0,         1'b0},
            '{REQ_QEMPTY,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1, 31'h0,         1'b0},
            '{REQ_NEAREST, 32'hFFFF_FFFF, 31'h0,         1'b0, 1'b1, 31'h7FFF_FFFF, 1'b0},
            '{REQ_NEAREST, 32'h8000_0000, 31'h0,         1'b0, 1'b0, 31'h0,         1'b0},
            '{REQ_CLEAR,   32'h0000_0000, 31'h0,         1'b0, 1'b0, 31'h0,         1'b0},
            '{REQ_NEAREST, 32'h0000_0005, 31'h0,         1'b0, 1'b0, 31'h0,         1'b0},
            '{REQ_PUT,     32'h0000_000A, 31'h7FFF_FFFF, 1'b1, 1'b0, 31'h0,         1'b0},
            '{REQ_PUT,     32'h0000_0014, 31'h5,         1'b0, 1'b0, 31'h0,         1'b0},
            '{REQ_FRAME,   32'h0000_0064, 31'h0,         1'b0, 1'b0, 31'h0,         1'b0},
            '{REQ_PUT,     32'h0000_00C8, 31'h28,        1'b1, 1'b0, 31'h0,         1'b0},
            '{REQ_PUT,     32'h0000_012C, 31'h32,        1'b1, 1'b0, 31'h0,         1'b0},
            '{REQ_PUT,     32'h0000_0078, 31'h4D,        1'b1, 1'b0, 31'h0,         1'b0},
            '{REQ_FRAME,   32'h0000_0096, 31'h0,         1'b0, 1'b0, 31'h0,         1'b0},
            '{REQ_FRAME,   32'h0000_000A, 31'h0,         1'b0, 1'b0, 31'h0,         1'b0},
            '{REQ_UNUSED5, 32'hAAAA_5555, 31'h2AAA_AAAA, 1'b1, 1'b0, 31'h0,         1'b0},
            '{REQ_UNUSED6, 32'h5555_AAAA, 31'h5555_5555, 1'b0, 1'b0, 31'h0,         1'b0},
            '{REQ_UNUSED7, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0, 31'h0,         1'b0},
            '{REQ_CLEAR,   32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0, 31'h0,         1'b0},
            '{REQ_PUT,     32'hFFFF_FFF0, 31'h5555_5555, 1'b1, 1'b0, 31'h0,         1'b0},
            '{REQ_PUT,     32'h0000_0008, 31'h3,         1'b0, 1'b0, 31'h0,         1'b0},
            '{REQ_FRAME,   32'h0000_0010, 31'h0,         1'b0, 1'b0, 31'h0,         1'b0}
        };

        // Hold reset, then release it.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) send_word(directed_rows[i]);

        // Random episodes, with one wrap-crossing run part-way through.
        random_start = useful_words;
        while (useful_words - random_start < RANDOM_WORDS) begin
            idle_on <= ($urandom_range(0, 3) != 0);
            if (!fill_done && useful_words - random_start >= RANDOM_WORDS / 2) begin
                fill_episode();
                fill_done = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                noise_episode();
            end else begin
                stream_episode();
            end
            if ($urandom_range(0, 5) == 0) wait_drained();
        end

        // Drain, then watch for stray words.
        wait_drained();
        repeat (2 * RING_DEPTH + 8) @(posedge aclk);
        if (expected_results.size() != 0)
            note_fault($sformatf("%0d results never arrived", expected_results.size()));

        $display("summary: %0d request words, %0d result words, %0d faults",
                 words_sent, results_seen, fault_count);
        $display("summary: ring held up to %0d entries, %0d oldest entries dropped",
                 peak_entries, wrap_drops);
        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ pts_frame_index_ring.f @@
hw/rtl/pfir_pkg.sv
hw/rtl/pfir_ring_mem.sv
hw/rtl/pfir_dist_unit.sv
hw/rtl/pts_frame_index_ring.sv
hw/rtl/pfir_checker.sv
verif/tb_top.sv
